// File: hw/rtl/nitlo_pkg.sv
// Package for the N-dimensional index linearizer: payload structs, widths,
// register indexes and pipeline record type. No dependencies.
package nitlo_pkg;

  localparam int FIELD_DIMS  = 6;
  localparam int DIMS_W      = 3;
  localparam int COORD_W     = 16;
  localparam int OFFSET_W    = 60;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;

  localparam int MAX_DIMS_DEF    = 6;
  localparam int EXTENT_BITS_DEF = 10;

  // Register indexes on the config port.
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_DIMS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_BASE = 3'd1;

  typedef struct packed {
    logic [DIMS_W-1:0]         point_dims;
    logic signed [COORD_W-1:0] coord_0;
    logic signed [COORD_W-1:0] coord_1;
    logic signed [COORD_W-1:0] coord_2;
    logic signed [COORD_W-1:0] coord_3;
    logic signed [COORD_W-1:0] coord_4;
    logic signed [COORD_W-1:0] coord_5;
  } in_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] linear_offset;
    logic                out_of_bounds;
  } out_t;

  // Record that travels down the per-dimension stages.
  typedef struct packed {
    logic [DIMS_W-1:0]                   pdims;
    logic [DIMS_W-1:0]                   common;
    logic [FIELD_DIMS-1:0][COORD_W-1:0]  coords;
    logic [OFFSET_W-1:0]                 acc;
    logic [OFFSET_W-1:0]                 coeff;
    logic                                oob;
  } pipe_t;

endpackage

// File: hw/rtl/nitlo_cfg_regs.sv
// Shape configuration registers: dimension count and per-dimension extents.
// Depends on nitlo_pkg.
module nitlo_cfg_regs #(
  parameter int EXTENT_BITS = nitlo_pkg::EXTENT_BITS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                cfg_we,
  input  logic [nitlo_pkg::CFG_IDX_W-1:0]                     cfg_index,
  input  logic [nitlo_pkg::CFG_DATA_W-1:0]                    cfg_wdata,
  output logic [nitlo_pkg::DIMS_W-1:0]                        shape_dims,
  output logic [nitlo_pkg::FIELD_DIMS-1:0][EXTENT_BITS-1:0]   extent
);
  import nitlo_pkg::*;

  logic [DIMS_W-1:0]                       shape_dims_r;
  logic [FIELD_DIMS-1:0][EXTENT_BITS-1:0]  extent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_dims_r <= '0;
      for (int i = 0; i < FIELD_DIMS; i++) begin
        extent_r[i] <= EXTENT_BITS'(1);
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_SHAPE_DIMS) begin
        shape_dims_r <= cfg_wdata[DIMS_W-1:0];
      end
      // Indexes past the last extent match nothing and drop the write.
      for (int i = 0; i < FIELD_DIMS; i++) begin
        if (cfg_index == CFG_IDX_W'(int'(CFG_EXTENT_BASE) + i)) begin
          extent_r[i] <= cfg_wdata[EXTENT_BITS-1:0];
        end
      end
    end
  end

  assign shape_dims = shape_dims_r;
  assign extent     = extent_r;

endmodule

// File: hw/rtl/nitlo_dim_stage.sv
// One pipeline stage of the linearizer: bounds check and accumulate for a
// single dimension. Depends on nitlo_pkg.
module nitlo_dim_stage #(
  parameter int DIM         = 0,
  parameter int EXTENT_BITS = nitlo_pkg::EXTENT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [EXTENT_BITS-1:0]  extent,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  nitlo_pkg::pipe_t        in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output nitlo_pkg::pipe_t        out_data
);
  import nitlo_pkg::*;

  logic                               valid_r;
  pipe_t                              data_r;
  pipe_t                              data_nxt;
  logic [COORD_W-1:0]                 coord;
  logic                               active;
  logic                               extra;
  logic                               too_big;
  logic [OFFSET_W+EXTENT_BITS-1:0]    term_full;
  logic [OFFSET_W+EXTENT_BITS-1:0]    coeff_full;

  assign coord   = in_data.coords[DIM];
  assign active  = DIMS_W'(DIM) < in_data.common;
  assign extra   = !active && (DIMS_W'(DIM) < in_data.pdims);
  assign too_big = coord[COORD_W-2:0] >= (COORD_W-1)'(extent);

  assign term_full  = in_data.coeff * coord[EXTENT_BITS-1:0];
  assign coeff_full = in_data.coeff * extent;

  always_comb begin
    data_nxt = in_data;
    if (active) begin
      if (coord[COORD_W-1] || too_big) begin
        data_nxt.oob = 1'b1;
      end else begin
        data_nxt.acc   = in_data.acc + term_full[OFFSET_W-1:0];
        data_nxt.coeff = coeff_full[OFFSET_W-1:0];
      end
    end else if (extra && (coord != '0)) begin
      data_nxt.oob = 1'b1;
    end
  end

  // Advance when empty or when the next stage takes our request.
  assign in_stall = valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_stall |=> valid_r && $stable(data_r))
    else $error("stage %0d lost a stalled request", DIM);

  a_common_le_pdims: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> data_r.common <= data_r.pdims)
    else $error("stage %0d common count exceeds point count", DIM);

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r |-> !in_stall)
    else $error("stage %0d stalls while empty", DIM);

endmodule

// File: hw/rtl/nd_index_to_linear_offset.sv
// Column-major N-dimensional index linearizer: entry register, one stage per
// dimension, output register. Throughput is one request per cycle when the
// output does not stall; each stage holds one 60x10 multiply-add and one 60x10
// multiply, and a stall backs up stage by stage, filling bubbles first.
// Reset clears all valid bits, shape_dims to 0 and every extent to 1.
// Depends on nitlo_pkg, nitlo_cfg_regs and nitlo_dim_stage.
module nd_index_to_linear_offset #(
  parameter int MAX_DIMS    = nitlo_pkg::MAX_DIMS_DEF,
  parameter int EXTENT_BITS = nitlo_pkg::EXTENT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [nitlo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nitlo_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  nitlo_pkg::in_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output nitlo_pkg::out_t                   out_data
);
  import nitlo_pkg::*;

  localparam int DIM_LIM = (MAX_DIMS < FIELD_DIMS) ? MAX_DIMS : FIELD_DIMS;

  logic [DIMS_W-1:0]                       shape_dims;
  logic [FIELD_DIMS-1:0][EXTENT_BITS-1:0]  extent;

  logic [DIMS_W-1:0]  pdims_c;
  logic [DIMS_W-1:0]  sdims_c;
  pipe_t              ent_nxt;
  pipe_t              ent_data_r;
  logic               ent_valid_r;

  logic  [DIM_LIM:0]  stg_valid;
  logic  [DIM_LIM:0]  stg_stall;
  pipe_t              stg_data [DIM_LIM+1];

  logic               last_stall;
  logic               out_valid_r;
  out_t               out_data_r;

  nitlo_cfg_regs #(
    .EXTENT_BITS (EXTENT_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .shape_dims (shape_dims),
    .extent     (extent)
  );

  // Saturate both dimension counts to the supported limit.
  assign pdims_c = (in_data.point_dims > DIMS_W'(DIM_LIM)) ? DIMS_W'(DIM_LIM)
                                                           : in_data.point_dims;
  assign sdims_c = (shape_dims > DIMS_W'(DIM_LIM)) ? DIMS_W'(DIM_LIM) : shape_dims;

  always_comb begin
    ent_nxt.pdims     = pdims_c;
    ent_nxt.common    = (pdims_c < sdims_c) ? pdims_c : sdims_c;
    ent_nxt.coords[0] = in_data.coord_0;
    ent_nxt.coords[1] = in_data.coord_1;
    ent_nxt.coords[2] = in_data.coord_2;
    ent_nxt.coords[3] = in_data.coord_3;
    ent_nxt.coords[4] = in_data.coord_4;
    ent_nxt.coords[5] = in_data.coord_5;
    ent_nxt.acc       = '0;
    ent_nxt.coeff     = OFFSET_W'(1);
    ent_nxt.oob       = 1'b0;
  end

  assign in_stall = ent_valid_r && stg_stall[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
    end else if (!in_stall) begin
      ent_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ent_data_r <= ent_nxt;
    end
  end

  assign stg_valid[0] = ent_valid_r;
  assign stg_data[0]  = ent_data_r;

  for (genvar k = 0; k < DIM_LIM; k++) begin : g_dim
    nitlo_dim_stage #(
      .DIM         (k),
      .EXTENT_BITS (EXTENT_BITS)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .extent    (extent[k]),
      .in_valid  (stg_valid[k]),
      .in_stall  (stg_stall[k]),
      .in_data   (stg_data[k]),
      .out_valid (stg_valid[k+1]),
      .out_stall (stg_stall[k+1]),
      .out_data  (stg_data[k+1])
    );
  end

  // Output register: zero the offset on a bounds error.
  assign last_stall         = out_valid_r && out_stall;
  assign stg_stall[DIM_LIM] = last_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!last_stall) begin
      out_valid_r <= stg_valid[DIM_LIM];
    end
  end

  always_ff @(posedge clk) begin
    if (!last_stall && stg_valid[DIM_LIM]) begin
      out_data_r.linear_offset <= stg_data[DIM_LIM].oob ? '0 : stg_data[DIM_LIM].acc;
      out_data_r.out_of_bounds <= stg_data[DIM_LIM].oob;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !ent_valid_r)
    else $error("pipeline not empty after reset");

  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.out_of_bounds |-> out_data_r.linear_offset == '0)
    else $error("out-of-bounds result carries a nonzero offset");

  a_entry_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    ent_valid_r |-> ent_data_r.pdims <= DIMS_W'(DIM_LIM)
                    && ent_data_r.common <= ent_data_r.pdims)
    else $error("entry dimension counts not clamped");

endmodule

// File: tb/nd_index_to_linear_offset_tb.sv
// Testbench for nd_index_to_linear_offset: directed and random points across several
// array shapes, checked against an in-bench column-major offset predictor.
// Depends on nitlo_pkg and the nd_index_to_linear_offset RTL.
module nd_index_to_linear_offset_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nitlo_pkg::*;

  localparam int DIM_LIMIT   = (MAX_DIMS_DEF < FIELD_DIMS) ? MAX_DIMS_DEF : FIELD_DIMS;
  localparam int EXT_MASK    = (1 << EXTENT_BITS_DEF) - 1;
  localparam int IDLE_PCT    = 16;
  localparam int SETTLE      = 16;
  localparam int WATCHDOG    = 4000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 120;

  // Index past the last extent register; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;

  nd_index_to_linear_offset u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Shadow copy of the shape registers.
  logic [DIMS_W-1:0]     shape_dims_cfg;
  logic [CFG_DATA_W-1:0] extent_cfg [FIELD_DIMS];

  in_t  point_q [$];
  out_t offset_q [$];
  out_t want;
  int   fail_cnt = 0;
  int   cyc = 0;
  int   idle_cyc = 0;
  logic quiet;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;
  assign quiet = (cyc >= 600 && cyc < 1100);

  function automatic out_t predict_offset(input in_t pt);
    logic [COORD_W-1:0]  c [FIELD_DIMS];
    int unsigned         pdims;
    int unsigned         sdims;
    int unsigned         common;
    logic [OFFSET_W-1:0] acc;
    logic [OFFSET_W-1:0] coeff;
    logic                oob;
    out_t                res;
    {c[0], c[1], c[2], c[3], c[4], c[5]} =
      {pt.coord_0, pt.coord_1, pt.coord_2, pt.coord_3, pt.coord_4, pt.coord_5};
    pdims  = (pt.point_dims > DIM_LIMIT) ? DIM_LIMIT : pt.point_dims;
    sdims  = (shape_dims_cfg > DIM_LIMIT) ? DIM_LIMIT : shape_dims_cfg;
    common = (pdims < sdims) ? pdims : sdims;
    acc    = '0;
    coeff  = 1;
    oob    = 1'b0;
    for (int i = 0; i < common; i++) begin
      if (c[i][COORD_W-1]) begin
        oob = 1'b1;
      end else if (c[i] >= {6'b0, extent_cfg[i]}) begin
        oob = 1'b1;
      end else begin
        acc   = acc + coeff * {44'b0, c[i]};
        coeff = coeff * {50'b0, extent_cfg[i]};
      end
    end
    // valid coordinates past the shape must be zero
    for (int i = common; i < pdims; i++) begin
      if (c[i] != '0) oob = 1'b1;
    end
    res.linear_offset = oob ? '0 : acc;
    res.out_of_bounds = oob;
    return res;
  endfunction

  function automatic in_t point(input logic [DIMS_W-1:0] pd,
                                input logic [COORD_W-1:0] a, b, c, d, e, f);
    in_t pt;
    pt = {pd, a, b, c, d, e, f};
    return pt;
  endfunction

  // Mostly in-range points for the current shape, with some broken ones mixed in.
  function automatic in_t make_point();
    logic [COORD_W-1:0] c [FIELD_DIMS];
    logic [DIMS_W-1:0]  pd;
    int unsigned        sd;
    int unsigned        pick;
    int unsigned        j;
    sd   = (shape_dims_cfg > DIM_LIMIT) ? DIM_LIMIT : shape_dims_cfg;
    pick = $urandom_range(0, 99);
    pd   = (pick < 60) ? DIMS_W'(sd) : DIMS_W'($urandom_range(0, 7));
    for (int i = 0; i < FIELD_DIMS; i++) begin
      if (i < sd && extent_cfg[i] != 0) begin
        c[i] = COORD_W'($urandom_range(0, extent_cfg[i] - 1));
      end else if (i < sd || i >= pd) begin
        c[i] = COORD_W'($urandom);
      end else begin
        c[i] = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom) : '0;
      end
    end
    if (pick >= 95) begin
      for (int i = 0; i < FIELD_DIMS; i++) c[i] = COORD_W'($urandom);
    end else if (pick >= 82) begin
      j = $urandom_range(0, FIELD_DIMS - 1);
      case ($urandom_range(0, 2))
        0: c[j] = COORD_W'($urandom);
        1: c[j] = {6'b0, extent_cfg[j]};
        default: c[j] = 16'h8000 | COORD_W'($urandom);
      endcase
    end
    return point(pd, c[0], c[1], c[2], c[3], c[4], c[5]);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_SHAPE_DIMS) begin
      shape_dims_cfg = val[DIMS_W-1:0];
    end else if (idx < CFG_EXTENT_BASE + FIELD_DIMS) begin
      extent_cfg[idx - CFG_EXTENT_BASE] = val & CFG_DATA_W'(EXT_MASK);
    end
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (in_valid || point_q.size() != 0 || offset_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_extent();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 10'd1023;
      2, 3: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Sender: hold the request until taken, predict at acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) offset_q.push_back(predict_offset(in_data));
      if (!in_valid || !in_stall) begin
        if (point_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_data  <= point_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall, compare each result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (offset_q.size() == 0) begin
          $error("unexpected result: linear_offset %0d out_of_bounds %0b",
                 out_data.linear_offset, out_data.out_of_bounds);
          fail_cnt++;
        end else begin
          want = offset_q.pop_front();
          if (out_data.linear_offset !== want.linear_offset) begin
            $error("linear_offset: expected %0d, got %0d",
                   want.linear_offset, out_data.linear_offset);
            fail_cnt++;
          end
          if (out_data.out_of_bounds !== want.out_of_bounds) begin
            $error("out_of_bounds: expected %0b, got %0b",
                   want.out_of_bounds, out_data.out_of_bounds);
            fail_cnt++;
          end
        end
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cyc <= 0;
    end else begin
      idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= WATCHDOG) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sd;
    shape_dims_cfg = '0;
    for (int i = 0; i < FIELD_DIMS; i++) extent_cfg[i] = 10'd1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset shape: no dimensions, so any valid nonzero coordinate is out of range.
    point_q.push_back(point(3'd0, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF));
    point_q.push_back(point(3'd3, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    point_q.push_back(point(3'd2, 16'h0, 16'h1, 16'h0, 16'h0, 16'h0, 16'h0));
    point_q.push_back(point(3'd7, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h8000));
    drain();

    // Largest shape: dimension count saturates, every extent at its top.
    write_reg(CFG_SHAPE_DIMS, 10'h3FF);
    for (int i = 0; i < FIELD_DIMS; i++) write_reg(3'(CFG_EXTENT_BASE + i), 10'd1023);
    end_writes();
    point_q.push_back(point(3'd6, 16'd1022, 16'd1022, 16'd1022, 16'd1022, 16'd1022, 16'd1022));
    point_q.push_back(point(3'd6, 16'd1023, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    point_q.push_back(point(3'd6, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF));
    point_q.push_back(point(3'd6, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    point_q.push_back(point(3'd6, 16'h0, 16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h0));
    point_q.push_back(point(3'd7, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6));
    point_q.push_back(point(3'd3, 16'd5, 16'd6, 16'd7, 16'hFFFF, 16'h8000, 16'h7FFF));
    point_q.push_back(point(3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    drain();

    // Zero extent in dimension 1; the unused index must not disturb anything.
    write_reg(CFG_SHAPE_DIMS, 10'd4);
    write_reg(3'(CFG_EXTENT_BASE + 0), 10'd3);
    write_reg(3'(CFG_EXTENT_BASE + 1), 10'd0);
    write_reg(3'(CFG_EXTENT_BASE + 2), 10'd5);
    write_reg(3'(CFG_EXTENT_BASE + 3), 10'd7);
    write_reg(3'(CFG_EXTENT_BASE + 4), 10'd2);
    write_reg(3'(CFG_EXTENT_BASE + 5), 10'd9);
    write_reg(CFG_UNUSED_IDX, 10'h3FF);
    end_writes();
    point_q.push_back(point(3'd1, 16'd2, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0));
    point_q.push_back(point(3'd2, 16'd0, 16'd0, 16'h0, 16'h0, 16'h0, 16'h0));
    point_q.push_back(point(3'd4, 16'd2, 16'd0, 16'd4, 16'd6, 16'h0, 16'h0));
    point_q.push_back(point(3'd6, 16'd1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h1));
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: sd = 0;
        1: sd = 6;
        2: sd = 7;
        default: sd = $urandom_range(0, 7);
      endcase
      write_reg(CFG_SHAPE_DIMS, {7'($urandom), 3'(sd)});
      for (int i = 0; i < FIELD_DIMS; i++) begin
        case (ph)
          1: write_reg(3'(CFG_EXTENT_BASE + i), 10'd1023);
          2: write_reg(3'(CFG_EXTENT_BASE + i), 10'd1);
          default: write_reg(3'(CFG_EXTENT_BASE + i), pick_extent());
        endcase
      end
      if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
      end_writes();
      repeat (PHASE_ITEMS) point_q.push_back(make_point());
      drain();
    end

    if (fail_cnt == 0 && offset_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: nd_index_to_linear_offset.f
hw/rtl/nitlo_pkg.sv
hw/rtl/nitlo_cfg_regs.sv
hw/rtl/nitlo_dim_stage.sv
hw/rtl/nd_index_to_linear_offset.sv
tb/nd_index_to_linear_offset_tb.sv
